// File: rtl/canonical_line_editor_ring_macros.svh
// Assertion macros used by the line editor top level.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef CANONICAL_LINE_EDITOR_RING_MACROS_SVH
`define CANONICAL_LINE_EDITOR_RING_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CLER_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define CLER_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/cler_pkg.sv
// Package for the canonical line editor: character codes, result kinds,
// sequencer states, pointer unit operations and configuration types. No dependencies.
package cler_pkg;

    localparam int CLER_RING_DEPTH = 64;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_KILL  = 8'h15;
    localparam logic [7:0] CH_ERASE = 8'h08;
    localparam logic [7:0] CH_EOF   = 8'h04;
    localparam logic [7:0] CH_DUMP  = 8'h10;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic       ECHO_ENABLE_RST = 1'b1;
    localparam logic [7:0] ERASE_CODE_RST  = 8'h08;

    typedef enum logic [1:0] {
        CFG_ECHO_ENABLE = 2'd0,
        CFG_ERASE_CODE  = 2'd1
    } cfg_index_t;

    typedef enum logic {
        ACT_RECEIVE = 1'b0,
        ACT_READ    = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_READ      = 3'd1,
        KIND_EOF_TAKEN = 3'd2,
        KIND_EOF_KEPT  = 3'd3,
        KIND_NONE      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ALU_PASS = 2'd0,
        ALU_INC  = 2'd1,
        ALU_DEC  = 2'd2,
        ALU_DIFF = 2'd3
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STORE,
        ST_ADVANCE,
        ST_COMMIT,
        ST_ERASE,
        ST_KILL_RD,
        ST_KILL_CHK,
        ST_KILL_END,
        ST_READ_RD,
        ST_READ_CHK
    } state_t;

    typedef struct packed {
        logic       echo_en;
        logic [7:0] erase_code;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic pend;
    } stat_t;

endpackage

// File: rtl/cler_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cler_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cler_ptr_alu.sv
// Shared pointer unit: increment, decrement, difference modulo twice the ring depth,
// and the ring slot of the result. Depends on cler_pkg.
module cler_ptr_alu import cler_pkg::*; #(
    parameter int RING_DEPTH = CLER_RING_DEPTH
) (
    input  alu_op_t                             op,
    input  logic [$clog2(2*RING_DEPTH)-1:0]     a,
    input  logic [$clog2(2*RING_DEPTH)-1:0]     b,
    output logic [$clog2(2*RING_DEPTH)-1:0]     res,
    output logic [$clog2(RING_DEPTH)-1:0]       res_slot
);

    localparam int PTR_W  = $clog2(2*RING_DEPTH);
    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W:0]   MOD_X   = (PTR_W+1)'(2*RING_DEPTH);
    localparam logic [PTR_W-1:0] MOD_M1  = PTR_W'(2*RING_DEPTH-1);
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);

    logic [PTR_W:0]   diff_wide;
    logic [PTR_W-1:0] slot_wide;

    always_comb
    begin
        diff_wide = {1'b0, a} + MOD_X - {1'b0, b};
        if (diff_wide >= MOD_X)
        begin
            diff_wide = diff_wide - MOD_X;
        end
        case (op)
            ALU_PASS: res = a;
            ALU_INC:  res = (a == MOD_M1) ? '0 : a + PTR_W'(1);
            ALU_DEC:  res = (a == '0) ? MOD_M1 : a - PTR_W'(1);
            ALU_DIFF: res = diff_wide[PTR_W-1:0];
            default:  res = a;
        endcase
        slot_wide = (res >= DEPTH_P) ? res - DEPTH_P : res;
        res_slot  = slot_wide[ADDR_W-1:0];
    end

endmodule

// File: rtl/cler_ctrl.sv
// Sequencer of the line editor: ring pointers, input capture, per-step control
// of the pointer unit and the ring RAM, and the output register. Depends on cler_pkg.
module cler_ctrl import cler_pkg::*; #(
    parameter int RING_DEPTH = CLER_RING_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cfg_t                                cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  action_t                             in_action,
    input  logic [7:0]                          in_byte,
    input  logic                                in_started,
    output logic                                out_valid,
    input  logic                                out_ready,
    output kind_t                               out_kind,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    output alu_op_t                             alu_op,
    output logic [$clog2(2*RING_DEPTH)-1:0]     alu_a,
    output logic [$clog2(2*RING_DEPTH)-1:0]     alu_b,
    input  logic [$clog2(2*RING_DEPTH)-1:0]     alu_res,
    input  logic [$clog2(RING_DEPTH)-1:0]       alu_slot,
    output logic                                ram_wr_en,
    output logic [$clog2(RING_DEPTH)-1:0]       ram_wr_addr,
    output logic [7:0]                          ram_wr_data,
    output logic                                ram_rd_en,
    output logic [$clog2(RING_DEPTH)-1:0]       ram_rd_addr,
    input  logic [7:0]                          ram_rd_data,
    output stat_t                               stat
);

    localparam int PTR_W = $clog2(2*RING_DEPTH);
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] read_reg, read_next;
    logic [PTR_W-1:0] commit_reg, commit_next;
    logic [PTR_W-1:0] edit_reg, edit_next;
    logic             pend_reg, pend_next;
    logic [7:0]       byte_reg;
    logic             started_reg;

    logic             out_valid_reg;
    kind_t            out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    logic             push;
    kind_t            push_kind;
    logic [7:0]       push_byte;
    logic             push_last;

    logic             out_free;
    logic             echo_go;
    logic             kill_go;
    logic             accept;
    logic             edit_empty;
    logic             ring_empty;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign echo_go    = !cfg.echo_en || out_free;
    // A held-back erase echo may only go out once the output register has room.
    assign kill_go    = !pend_reg || out_free;
    assign edit_empty = (edit_reg == commit_reg);
    assign ring_empty = (read_reg == commit_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == ACT_READ)
                    begin
                        state_next = ST_READ_RD;
                    end
                    else if (in_byte == CH_KILL)
                    begin
                        state_next = ST_KILL_RD;
                    end
                    else if (in_byte == CH_ERASE || in_byte == CH_DEL)
                    begin
                        state_next = ST_ERASE;
                    end
                    else if (in_byte == CH_DUMP || in_byte == CH_NUL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:    state_next = (alu_res < DEPTH_P) ? ST_STORE : ST_IDLE;
            ST_STORE:    state_next = echo_go ? ST_ADVANCE : ST_STORE;
            ST_ADVANCE:  state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_IDLE;
            ST_ERASE:    state_next = (edit_empty || echo_go) ? ST_IDLE : ST_ERASE;
            ST_KILL_RD:  state_next = edit_empty ? ST_KILL_END : ST_KILL_CHK;
            ST_KILL_CHK:
            begin
                if (ram_rd_data == CH_LF)
                begin
                    state_next = ST_KILL_END;
                end
                else if (kill_go)
                begin
                    state_next = ST_KILL_RD;
                end
            end
            ST_KILL_END: state_next = kill_go ? ST_IDLE : ST_KILL_END;
            ST_READ_RD:
            begin
                if (!ring_empty)
                begin
                    state_next = ST_READ_CHK;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_CHK: state_next = out_free ? ST_IDLE : ST_READ_CHK;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        alu_op      = ALU_PASS;
        alu_a       = edit_reg;
        alu_b       = read_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = alu_slot;
        ram_wr_data = byte_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = alu_slot;
        push        = 1'b0;
        push_kind   = KIND_ECHO;
        push_byte   = cfg.erase_code;
        push_last   = 1'b1;
        edit_next   = edit_reg;
        read_next   = read_reg;
        commit_next = commit_reg;
        pend_next   = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_CHECK:
            begin
                alu_op = ALU_DIFF;
            end
            ST_STORE:
            begin
                ram_wr_en = echo_go;
                push      = echo_go && cfg.echo_en;
                push_byte = byte_reg;
            end
            ST_ADVANCE:
            begin
                alu_op    = ALU_INC;
                edit_next = alu_res;
            end
            ST_COMMIT:
            begin
                alu_op = ALU_DIFF;
                if (byte_reg == CH_LF || byte_reg == CH_EOF || alu_res == DEPTH_P)
                begin
                    commit_next = edit_reg;
                end
            end
            ST_ERASE:
            begin
                alu_op = ALU_DEC;
                if (!edit_empty && echo_go)
                begin
                    edit_next = alu_res;
                    push      = cfg.echo_en;
                end
            end
            ST_KILL_RD:
            begin
                alu_op    = ALU_DEC;
                ram_rd_en = !edit_empty;
            end
            ST_KILL_CHK:
            begin
                // The echo of the previous erased byte is held until it is known
                // whether another one follows, so that only the final one is last.
                alu_op    = ALU_DEC;
                push_last = 1'b0;
                if (ram_rd_data != CH_LF && kill_go)
                begin
                    edit_next = alu_res;
                    push      = pend_reg;
                    pend_next = cfg.echo_en;
                end
            end
            ST_KILL_END:
            begin
                if (pend_reg && out_free)
                begin
                    push      = 1'b1;
                    pend_next = 1'b0;
                end
            end
            ST_READ_RD:
            begin
                alu_a     = read_reg;
                ram_rd_en = !ring_empty;
                push_kind = KIND_NONE;
                push_byte = '0;
                push      = ring_empty && out_free;
            end
            ST_READ_CHK:
            begin
                alu_op = ALU_INC;
                alu_a  = read_reg;
                push   = out_free;
                if (ram_rd_data == CH_EOF)
                begin
                    push_byte = '0;
                    if (started_reg)
                    begin
                        push_kind = KIND_EOF_KEPT;
                    end
                    else
                    begin
                        push_kind = KIND_EOF_TAKEN;
                        if (out_free)
                        begin
                            read_next = alu_res;
                        end
                    end
                end
                else
                begin
                    push_kind = KIND_READ;
                    push_byte = ram_rd_data;
                    if (out_free)
                    begin
                        read_next = alu_res;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            read_reg      <= '0;
            commit_reg    <= '0;
            edit_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            read_reg   <= read_next;
            commit_reg <= commit_next;
            edit_reg   <= edit_next;
            pend_reg   <= pend_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg    <= (in_byte == CH_CR) ? CH_LF : in_byte;
            started_reg <= in_started;
        end
        if (push)
        begin
            out_kind_reg <= push_kind;
            out_byte_reg <= push_byte;
            out_last_reg <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign stat.idle = in_ready;
    assign stat.pend = pend_reg;

endmodule

// File: rtl/canonical_line_editor_ring.sv
// Canonical line editor over a byte ring, one transaction at a time. A stored byte passes the
// check, store, advance and commit steps; a byte is dropped at the check step on a full ring,
// and NUL and CH_DUMP bytes are ignored outright. A result not yet taken stalls the sequencer.
// Reset clears pointers and the sequencer and loads the register defaults; no clearing pass.
module canonical_line_editor_ring import cler_pkg::*; #(
    parameter int RING_DEPTH = CLER_RING_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // in_byte[7:0], read_started[8], zero fill
    input  logic        s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    `include "canonical_line_editor_ring_macros.svh"

    localparam int PTR_W  = $clog2(2*RING_DEPTH);
    localparam int ADDR_W = $clog2(RING_DEPTH);

    logic             echo_en_reg;
    logic [7:0]       erase_code_reg;
    cfg_t             cfg;
    stat_t            stat;
    kind_t            out_kind;

    alu_op_t          alu_op;
    logic [PTR_W-1:0] alu_a;
    logic [PTR_W-1:0] alu_b;
    logic [PTR_W-1:0] alu_res;
    logic [ADDR_W-1:0] alu_slot;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg    <= ECHO_ENABLE_RST;
            erase_code_reg <= ERASE_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ECHO_ENABLE: echo_en_reg    <= cfg_data[0];
                CFG_ERASE_CODE:  erase_code_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.echo_en    = echo_en_reg;
    assign cfg.erase_code = erase_code_reg;

    cler_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (action_t'(s_tuser)),
        .in_byte     (s_tdata[7:0]),
        .in_started  (s_tdata[8]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_byte    (m_tdata),
        .out_last    (m_tlast),
        .alu_op      (alu_op),
        .alu_a       (alu_a),
        .alu_b       (alu_b),
        .alu_res     (alu_res),
        .alu_slot    (alu_slot),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .stat        (stat)
    );

    cler_ptr_alu #(
        .RING_DEPTH (RING_DEPTH)
    ) u_alu (
        .op       (alu_op),
        .a        (alu_a),
        .b        (alu_b),
        .res      (alu_res),
        .res_slot (alu_slot)
    );

    cler_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tuser = out_kind;

    // A held erase echo must have been flushed before a new transaction is taken.
    `CLER_ASSERT_IMPL(a_idle_no_pend, stat.idle, !stat.pend, "erase echo left pending while idle")
    // Only echo results may be followed by more results of the same item.
    `CLER_ASSERT_IMPL(a_non_echo_last, m_tvalid && m_tuser != KIND_ECHO, m_tlast,
        "read result without last")
    `CLER_ASSERT_IMPL(a_status_zero_byte,
        m_tvalid && (m_tuser == KIND_EOF_TAKEN || m_tuser == KIND_EOF_KEPT ||
        m_tuser == KIND_NONE), m_tdata == 8'h00, "status result carries a nonzero byte")

endmodule

// File: verif/canonical_line_editor_ring_tb.sv
// Self-checking testbench for canonical_line_editor_ring: drives receive and read transactions
// and compares every result transaction against a predictor of the line editor's ring state.
// Depends on cler_pkg and the canonical_line_editor_ring RTL only.
module canonical_line_editor_ring_tb;
    import cler_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = CLER_RING_DEPTH;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int PTR_W  = SLOT_W + 1;
    localparam int DIR_ROWS = 23;
    // Quiet time before a register write or the end: a full line kill with echo off
    // walks up to 63 bytes and emits nothing.
    localparam int DRAIN_CYCLES = 300;

    // Register indexes that the block does not implement.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        action_t    act;
        logic [7:0] ch;
        logic       started;
        logic       typed;      // expectation written in the row itself
        logic       typed_one;  // typed row gives one result, else none
        kind_t      exp_kind;
        logic [7:0] exp_byte;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // in_byte[7:0], read_started[8], zero fill
    logic        s_tuser;   // action[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic [2:0]  m_tuser;   // kind[2:0]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    canonical_line_editor_ring DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor copy of the editor state and its registers.
    logic [7:0]       line_copy [DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] cm_ptr;
    logic [PTR_W-1:0] ed_ptr;
    logic             echo_on;
    logic [7:0]       erase_code;

    result_t   step_results [$];
    result_t   pending_results [$];
    result_t   oldest_result;
    stim_row_t directed_rows [DIR_ROWS];
    int        mismatches;
    int        burst_left;

    function automatic logic [SLOT_W-1:0] slot_of(logic [PTR_W-1:0] p);
        return p[SLOT_W-1:0];
    endfunction

    function automatic void add_echo(logic [7:0] b);
        if (echo_on)
            step_results.push_back('{KIND_ECHO, b, 1'b0});
    endfunction

    // Advances the editor copy by one transaction and leaves its results in step_results.
    function automatic void predict_editor(action_t act, logic [7:0] ch, logic started);
        logic [7:0]       c;
        logic [7:0]       b;
        logic [PTR_W-1:0] prev;
        logic [PTR_W-1:0] fill;
        c = ch;
        step_results.delete();
        if (act == ACT_RECEIVE)
        begin
            if (c == CH_KILL)
            begin
                // Walk back to the commit point, but never past a stored line feed.
                prev = ed_ptr - 1'b1;
                while (ed_ptr != cm_ptr && line_copy[slot_of(prev)] != CH_LF)
                begin
                    ed_ptr = prev;
                    add_echo(erase_code);
                    prev = ed_ptr - 1'b1;
                end
            end
            else if (c == CH_ERASE || c == CH_DEL)
            begin
                if (ed_ptr != cm_ptr)
                begin
                    ed_ptr = ed_ptr - 1'b1;
                    add_echo(erase_code);
                end
            end
            else if (c != CH_DUMP && c != CH_NUL)
            begin
                fill = ed_ptr - rd_ptr;
                if (fill < DEPTH)
                begin
                    if (c == CH_CR)
                        c = CH_LF;
                    add_echo(c);
                    line_copy[slot_of(ed_ptr)] = c;
                    ed_ptr = ed_ptr + 1'b1;
                    fill = ed_ptr - rd_ptr;
                    if (c == CH_LF || c == CH_EOF || fill == DEPTH)
                        cm_ptr = ed_ptr;
                end
            end
        end
        else if (rd_ptr == cm_ptr)
        begin
            step_results.push_back('{KIND_NONE, CH_NUL, 1'b0});
        end
        else
        begin
            b = line_copy[slot_of(rd_ptr)];
            if (b == CH_EOF)
            begin
                if (started)
                    step_results.push_back('{KIND_EOF_KEPT, CH_NUL, 1'b0});
                else
                begin
                    rd_ptr = rd_ptr + 1'b1;
                    step_results.push_back('{KIND_EOF_TAKEN, CH_NUL, 1'b0});
                end
            end
            else
            begin
                rd_ptr = rd_ptr + 1'b1;
                step_results.push_back('{KIND_READ, b, 1'b0});
            end
        end
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Sender: bursts of back-to-back transactions separated by random gaps.
    task automatic send_item(input stim_row_t row);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
            burst_left = $urandom_range(10, 1);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.act;
        s_tdata  <= {7'd0, row.started, row.ch};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        predict_editor(row.act, row.ch, row.started);
        if (row.typed)
        begin
            if (row.typed_one)
                pending_results.push_back('{row.exp_kind, row.exp_byte, 1'b1});
        end
        else
        begin
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic send_plain(input action_t act, input logic [7:0] ch, input logic started);
        send_item('{act, ch, started, 1'b0, 1'b0, KIND_ECHO, CH_NUL});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_ECHO_ENABLE)
            echo_on = value[0];
        else if (idx == CFG_ERASE_CODE)
            erase_code = value;
    endtask

    // Mostly typed lines with edits and a terminator, plus read bursts and raw noise.
    task automatic run_random(input int target);
        int sent;
        int len;
        int pick;
        int r;
        logic [7:0] ch;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 45)
            begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 60)
                                                  : $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                begin
                    r = $urandom_range(15, 0);
                    if (r == 0)
                        ch = CH_KILL;
                    else if (r == 1)
                        ch = CH_ERASE;
                    else if (r == 2)
                        ch = CH_DEL;
                    else
                        ch = 8'($urandom_range(126, 32));
                    send_plain(ACT_RECEIVE, ch, 1'($urandom_range(1, 0)));
                    sent++;
                end
                r = $urandom_range(2, 0);
                ch = (r == 0) ? CH_CR : ((r == 1) ? CH_LF : CH_EOF);
                send_plain(ACT_RECEIVE, ch, 1'($urandom_range(1, 0)));
                sent++;
            end
            else if (pick < 80)
            begin
                len = $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                begin
                    send_plain(ACT_READ, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
                    sent++;
                end
            end
            else
            begin
                ch = 8'($urandom_range(255, 0));
                r = $urandom_range(1, 0);
                send_plain(action_t'(r), ch, 1'($urandom_range(1, 0)));
                // Bytes that the editor drops outright do not count.
                if (r == ACT_READ || (ch != CH_NUL && ch != CH_DUMP))
                    sent++;
            end
        end
    endtask

    // Receiver: ready pattern switches between open, random and sparse, each held for a random stretch.
    int       stall_mode;
    int       stall_left;
    logic [1:0] stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_mode  <= 0;
            stall_left  <= 0;
            stall_phase <= 2'd0;
        end
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(2, 0);
                stall_left <= $urandom_range(96, 16);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1, 0));
                default: m_tready <= (stall_phase == 2'd0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                          m_tuser, m_tdata, m_tlast));
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tuser !== oldest_result.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              m_tuser, oldest_result.kind));
                if (m_tdata !== oldest_result.data)
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              m_tdata, oldest_result.data));
                if (m_tlast !== oldest_result.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_tlast, oldest_result.last));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("canonical_line_editor_ring_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'd0;
        s_tuser   <= ACT_RECEIVE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ECHO_ENABLE;
        cfg_data  <= 8'd0;
        mismatches = 0;
        burst_left = 0;
        rd_ptr = '0;
        cm_ptr = '0;
        ed_ptr = '0;
        echo_on = ECHO_ENABLE_RST;
        erase_code = ERASE_CODE_RST;
        foreach (line_copy[i])
            line_copy[i] = 8'd0;

        // Edits on an empty line, a committed line and a kill, then reads through both
        // ways a Ctrl-D can end a read.
        directed_rows = '{
            '{ACT_READ,    CH_NUL,   1'b0, 1'b1, 1'b1, KIND_NONE,      CH_NUL},
            '{ACT_RECEIVE, CH_NUL,   1'b0, 1'b1, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_DUMP,  1'b0, 1'b1, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_ERASE, 1'b0, 1'b1, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_DEL,   1'b0, 1'b1, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_KILL,  1'b0, 1'b1, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, 8'h61,    1'b0, 1'b1, 1'b1, KIND_ECHO,      8'h61},
            '{ACT_RECEIVE, 8'hFF,    1'b1, 1'b1, 1'b1, KIND_ECHO,      8'hFF},
            '{ACT_RECEIVE, 8'h01,    1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_DEL,   1'b0, 1'b1, 1'b1, KIND_ECHO,      ERASE_CODE_RST},
            '{ACT_RECEIVE, CH_CR,    1'b0, 1'b1, 1'b1, KIND_ECHO,      CH_LF},
            '{ACT_RECEIVE, 8'h62,    1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, 8'h63,    1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_KILL,  1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, 8'h78,    1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_RECEIVE, CH_EOF,   1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_READ,    8'hFF,    1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_READ,    CH_NUL,   1'b1, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_READ,    CH_NUL,   1'b1, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_READ,    CH_NUL,   1'b0, 1'b0, 1'b0, KIND_ECHO,      CH_NUL},
            '{ACT_READ,    CH_NUL,   1'b1, 1'b1, 1'b1, KIND_EOF_KEPT,  CH_NUL},
            '{ACT_READ,    CH_NUL,   1'b0, 1'b1, 1'b1, KIND_EOF_TAKEN, CH_NUL},
            '{ACT_READ,    CH_NUL,   1'b0, 1'b1, 1'b1, KIND_NONE,      CH_NUL}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        drain_results();

        write_register(CFG_ECHO_ENABLE, 8'h01);
        write_register(CFG_ERASE_CODE, 8'hFF);
        run_random(25);
        drain_results();

        // Echo off: receive transactions go silent, reads still answer.
        write_register(CFG_ECHO_ENABLE, 8'hFE);
        write_register(CFG_ERASE_CODE, 8'h00);
        write_register(CFG_SPARE_A, 8'($urandom_range(255, 0)));
        write_register(CFG_SPARE_B, 8'($urandom_range(255, 0)));
        run_random(25);
        drain_results();

        write_register(CFG_ECHO_ENABLE, 8'h01);
        write_register(CFG_ERASE_CODE, 8'($urandom_range(255, 0)));
        run_random(25);
        drain_results();

        if (mismatches == 0)
            $display("canonical_line_editor_ring_tb: clean");
        else
            $display("canonical_line_editor_ring_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cler_pkg.sv
rtl/cler_ram.sv
rtl/cler_ptr_alu.sv
rtl/cler_ctrl.sv
rtl/canonical_line_editor_ring.sv
verif/canonical_line_editor_ring_tb.sv
